/* src/fcpr_pkg.sv */
// Shared types and constants for the framed command packet receiver.
package fcpr_pkg;

    localparam int LEN_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int TIME_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 1;

    localparam logic [BYTE_W-1:0] HDR_ONE = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR_TWO = 8'h55;

    localparam logic [TIME_W-1:0] TIMEOUT_RST  = 16'd100;
    localparam logic [BYTE_W-1:0] OWN_ADDR_RST = 8'd1;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_OWN_ADDR = 1'b0;
    localparam logic [CFG_A_W-1:0] REG_TIMEOUT  = 1'b1;

    typedef logic [1:0] event_t;

    localparam event_t EV_CMD    = 2'd0;
    localparam event_t EV_DATA   = 2'd1;
    localparam event_t EV_RESEND = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic   tick;
        logic   clr_elapsed;
        logic   ld_addr;
        logic   ld_cmd;
        logic   ld_len;
        logic   wr_data;
        logic   start_rd;
        logic   adv_rd;
        logic   out_load;
        event_t out_sel;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic timed_out;
        logic is_hdr1;
        logic is_hdr2;
        logic byte_zero;
        logic len_ok;
        logic data_done;
        logic sum_ok;
        logic addr_match;
        logic len_zero;
        logic last_data;
        logic out_free;
    } dp_stat_t;

endpackage

/* src/fcpr_ctrl.sv */
// Frame parser and result sequencer state machine.
module fcpr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    output logic                s_tready,
    input  fcpr_pkg::dp_stat_t  stat,
    output fcpr_pkg::ctl_cmd_t  cmd
);
    import fcpr_pkg::*;

    localparam logic [3:0] ST_HDR1   = 4'd0;
    localparam logic [3:0] ST_HDR2   = 4'd1;
    localparam logic [3:0] ST_ADDR   = 4'd2;
    localparam logic [3:0] ST_CMD    = 4'd3;
    localparam logic [3:0] ST_LEN    = 4'd4;
    localparam logic [3:0] ST_DATA   = 4'd5;
    localparam logic [3:0] ST_SUM    = 4'd6;
    localparam logic [3:0] ST_EM_CMD = 4'd7;
    localparam logic [3:0] ST_EM_DAT = 4'd8;
    localparam logic [3:0] ST_EM_RSD = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] parse_state;
    logic       accept;
    logic       byte_in;

    assign s_tready = (state_reg <= ST_SUM);
    assign accept   = s_tvalid && s_tready;
    assign byte_in  = accept && !s_tuser;

    // a late byte restarts the search for a header
    assign parse_state = stat.timed_out ? ST_HDR1 : state_reg;

    always_comb begin
        cmd        = '0;
        cmd.tick   = accept && s_tuser;
        state_next = state_reg;
        case (state_reg)
            ST_EM_CMD: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = EV_CMD;
                    state_next   = stat.len_zero ? ST_HDR1 : ST_EM_DAT;
                end
            end
            ST_EM_DAT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = EV_DATA;
                    cmd.adv_rd   = 1'b1;
                    if (stat.last_data) begin
                        state_next = ST_HDR1;
                    end
                end
            end
            ST_EM_RSD: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = EV_RESEND;
                    state_next   = ST_HDR1;
                end
            end
            default: begin
                if (byte_in) begin
                    case (parse_state)
                        ST_HDR1: begin
                            if (stat.is_hdr1) begin
                                cmd.clr_elapsed = 1'b1;
                                state_next      = ST_HDR2;
                            end else begin
                                state_next = ST_HDR1;
                            end
                        end
                        ST_HDR2: begin
                            state_next = stat.is_hdr2 ? ST_ADDR : ST_HDR1;
                        end
                        ST_ADDR: begin
                            if (stat.byte_zero) begin
                                state_next = ST_HDR1;
                            end else begin
                                cmd.ld_addr = 1'b1;
                                state_next  = ST_CMD;
                            end
                        end
                        ST_CMD: begin
                            cmd.ld_cmd = 1'b1;
                            state_next = ST_LEN;
                        end
                        ST_LEN: begin
                            cmd.ld_len = 1'b1;
                            if (stat.byte_zero) begin
                                state_next = ST_SUM;
                            end else if (stat.len_ok) begin
                                state_next = ST_DATA;
                            end else begin
                                state_next = ST_HDR1;
                            end
                        end
                        ST_DATA: begin
                            cmd.wr_data = 1'b1;
                            if (stat.data_done) begin
                                state_next = ST_SUM;
                            end
                        end
                        ST_SUM: begin
                            if (!stat.sum_ok) begin
                                state_next = ST_EM_RSD;
                            end else if (stat.addr_match) begin
                                cmd.start_rd = 1'b1;
                                state_next   = ST_EM_CMD;
                            end else begin
                                state_next = ST_HDR1;
                            end
                        end
                        default: begin
                            state_next = ST_HDR1;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HDR1;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/fcpr_dpath.sv */
// Frame fields, checksum, payload memory, timer and output register.
module fcpr_dpath #(
    parameter int MAX_DATA = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [fcpr_pkg::BYTE_W-1:0]       rx_byte,
    input  logic                              cfg_wr_en,
    input  logic [fcpr_pkg::CFG_A_W-1:0]      cfg_addr,
    input  logic [fcpr_pkg::CFG_W-1:0]        cfg_wdata,
    input  fcpr_pkg::ctl_cmd_t                cmd,
    output fcpr_pkg::dp_stat_t                stat,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output fcpr_pkg::event_t                  m_event,
    output logic [fcpr_pkg::BYTE_W-1:0]       m_command,
    output logic [fcpr_pkg::LEN_W-1:0]        m_length,
    output logic [fcpr_pkg::BYTE_W-1:0]       m_data_byte,
    output logic                              m_last
);
    import fcpr_pkg::*;

    localparam int IDX_W     = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int MEM_DEPTH = 1 << IDX_W;

    logic [BYTE_W-1:0] own_addr_reg;
    logic [TIME_W-1:0] timeout_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [BYTE_W-1:0] addr_reg;
    logic [BYTE_W-1:0] cmd_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  count_reg;
    logic [LEN_W-1:0]  count_inc;
    logic [BYTE_W-1:0] sum_reg;
    logic [LEN_W-1:0]  rd_ptr_reg;
    logic [LEN_W-1:0]  rd_ptr_next;
    logic [LEN_W-1:0]  rd_ptr_inc;
    logic [BYTE_W-1:0] rdata_reg;
    logic [BYTE_W-1:0] mem [MEM_DEPTH];

    logic              out_valid_reg;
    event_t            out_event_reg;
    logic [BYTE_W-1:0] out_cmd_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;

    assign count_inc  = count_reg + LEN_W'(1);
    assign rd_ptr_inc = rd_ptr_reg + LEN_W'(1);

    always_comb begin
        stat            = '0;
        stat.timed_out  = (elapsed_reg >= timeout_reg);
        stat.is_hdr1    = (rx_byte == HDR_ONE);
        stat.is_hdr2    = (rx_byte == HDR_TWO);
        stat.byte_zero  = (rx_byte == '0);
        stat.len_ok     = (rx_byte <= BYTE_W'(MAX_DATA));
        stat.data_done  = (count_inc >= len_reg);
        stat.sum_ok     = (rx_byte == sum_reg);
        stat.addr_match = (addr_reg == own_addr_reg);
        stat.len_zero   = (len_reg == '0);
        stat.last_data  = (rd_ptr_inc == len_reg);
        stat.out_free   = !out_valid_reg || m_tready;
    end

    // read address runs one step ahead so rdata_reg always matches rd_ptr_reg
    always_comb begin
        if (cmd.start_rd) begin
            rd_ptr_next = '0;
        end else if (cmd.adv_rd) begin
            rd_ptr_next = rd_ptr_inc;
        end else begin
            rd_ptr_next = rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_data) begin
            mem[count_reg[IDX_W-1:0]] <= rx_byte;
        end
        rdata_reg <= mem[rd_ptr_next[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg  <= OWN_ADDR_RST;
            timeout_reg   <= TIMEOUT_RST;
            elapsed_reg   <= '0;
            addr_reg      <= '0;
            cmd_reg       <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_OWN_ADDR: own_addr_reg <= cfg_wdata[BYTE_W-1:0];
                    REG_TIMEOUT:  timeout_reg  <= cfg_wdata[TIME_W-1:0];
                    default:      ;
                endcase
            end
            // clear the timer on a first header byte, else count ticks and saturate
            if (cmd.clr_elapsed) begin
                elapsed_reg <= '0;
            end else if (cmd.tick && (elapsed_reg != '1)) begin
                elapsed_reg <= elapsed_reg + TIME_W'(1);
            end
            if (cmd.ld_addr) begin
                addr_reg <= rx_byte;
                sum_reg  <= rx_byte;
            end
            if (cmd.ld_cmd) begin
                cmd_reg <= rx_byte;
                sum_reg <= sum_reg + rx_byte;
            end
            if (cmd.ld_len) begin
                sum_reg   <= sum_reg + rx_byte;
                count_reg <= '0;
                if (rx_byte <= BYTE_W'(MAX_DATA)) begin
                    len_reg <= rx_byte[LEN_W-1:0];
                end
            end
            if (cmd.wr_data) begin
                sum_reg   <= sum_reg + rx_byte;
                count_reg <= count_inc;
            end
            rd_ptr_reg <= rd_ptr_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_event_reg <= cmd.out_sel;
            case (cmd.out_sel)
                EV_CMD: begin
                    out_cmd_reg  <= cmd_reg;
                    out_len_reg  <= len_reg;
                    out_data_reg <= '0;
                    out_last_reg <= (len_reg == '0);
                end
                EV_DATA: begin
                    out_cmd_reg  <= cmd_reg;
                    out_len_reg  <= len_reg;
                    out_data_reg <= rdata_reg;
                    out_last_reg <= (rd_ptr_inc == len_reg);
                end
                default: begin
                    out_cmd_reg  <= '0;
                    out_len_reg  <= '0;
                    out_data_reg <= '0;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign m_event     = out_event_reg;
    assign m_command   = out_cmd_reg;
    assign m_length    = out_len_reg;
    assign m_data_byte = out_data_reg;
    assign m_last      = out_last_reg;

endmodule

/* src/framed_command_packet_receiver.sv */
// Top level of the framed command packet receiver.
//
// Input stream: s_tuser selects a received byte (0) or a one millisecond
// tick (1); s_tdata[7:0] carries the byte. Each transaction is taken in the
// cycle it is offered while the parser waits for a byte; s_tready drops
// while results of a finished frame are being sent.
// Output stream: one transaction per result; m_tuser is the event (command,
// data byte, resend request), m_tlast marks the final result of a frame.
// A good checksum byte for this address is followed by the command result
// from the ST_EM_CMD state and the output register, then by one data result
// per cycle while the receiver keeps up, and the next input byte is taken
// once the last result is loaded; a bad checksum gives one resend result.
// Data results come from the registered payload memory read. A stalled
// receiver holds m_tvalid and the result, and the sequence continues once
// m_tready returns; input waits meanwhile.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr (0 = own
// address, 1 = timeout in ticks); the user writes only while the block is
// idle; the block does not enforce it. Reset (aresetn low, synchronous)
// returns to header search, clears the timer, sets own address 1, timeout 100.
module framed_command_packet_receiver #(
    parameter int MAX_DATA = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] rx_byte
    input  logic                              s_tuser,  // [0] kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] command, [12:8] length, [20:13] data_byte, [23:21] zero
    output logic [23:0]                       m_tdata,
    output logic [1:0]                        m_tuser,  // [1:0] event_res
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [fcpr_pkg::CFG_A_W-1:0]      cfg_addr,
    input  logic [fcpr_pkg::CFG_W-1:0]        cfg_wdata
);
    import fcpr_pkg::*;

    ctl_cmd_t          cmd;
    dp_stat_t          stat;
    event_t            m_event;
    logic [BYTE_W-1:0] m_command;
    logic [LEN_W-1:0]  m_length;
    logic [BYTE_W-1:0] m_data_byte;
    logic              m_last_int;

    fcpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fcpr_dpath #(
        .MAX_DATA (MAX_DATA)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rx_byte     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_event     (m_event),
        .m_command   (m_command),
        .m_length    (m_length),
        .m_data_byte (m_data_byte),
        .m_last      (m_last_int)
    );

    assign m_tdata = {3'b000, m_data_byte, m_length, m_command};
    assign m_tuser = m_event;
    assign m_tlast = m_last_int;

`ifndef NO_ASSERTIONS
    // a resend request always stands alone
    a_resend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == EV_RESEND)) |-> m_tlast)
        else $error("resend result without last");

    // data results only come from frames with a payload
    a_data_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == EV_DATA)) |-> (m_tdata[12:8] != '0))
        else $error("data result with zero length");

    // never load a result while input is being taken
    a_load_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !s_tready)
        else $error("result loaded while parser accepts input");
`endif

endmodule

/* tb/sv/framed_command_packet_receiver_tb.sv */
// Self-checking testbench for the framed command packet receiver.
`timescale 1ns / 1ps

module framed_command_packet_receiver_tb;
    import fcpr_pkg::*;

    localparam int MAX_DATA    = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 24;

    typedef enum logic [2:0] {
        SEEK_HDR1, SEEK_HDR2, GET_ADDR, GET_CMD, GET_LEN, GET_DATA, GET_SUM
    } parse_phase_t;

    typedef struct packed {
        event_t             ev;
        logic [BYTE_W-1:0]  cmd;
        logic [LEN_W-1:0]   len;
        logic [BYTE_W-1:0]  data;
        logic               last;
    } rx_event_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] rx;
    } rx_item_t;

    class frame_scoreboard;
        logic [BYTE_W-1:0] own_addr;
        logic [TIME_W-1:0] timeout_ticks;
        parse_phase_t      phase;
        logic [BYTE_W-1:0] frm_addr;
        logic [BYTE_W-1:0] frm_cmd;
        logic [LEN_W-1:0]  frm_len;
        logic [LEN_W-1:0]  data_cnt;
        logic [BYTE_W-1:0] run_sum;
        logic [BYTE_W-1:0] payload [16];
        logic [TIME_W-1:0] elapsed;
        rx_event_t         expected_events [$];
        int                errors;

        function new();
            own_addr      = OWN_ADDR_RST;
            timeout_ticks = TIMEOUT_RST;
            phase         = SEEK_HDR1;
            frm_addr      = '0;
            frm_cmd       = '0;
            frm_len       = '0;
            data_cnt      = '0;
            run_sum       = '0;
            elapsed       = '0;
            errors        = 0;
            foreach (payload[i]) payload[i] = '0;
        endfunction

        function void set_reg(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_OWN_ADDR) own_addr = val[BYTE_W-1:0];
            else if (idx == REG_TIMEOUT) timeout_ticks = val[TIME_W-1:0];
        endfunction

        function void push_event(event_t ev, logic [BYTE_W-1:0] cmd, logic [LEN_W-1:0] len,
                                 logic [BYTE_W-1:0] data, logic last);
            rx_event_t e;
            e.ev   = ev;
            e.cmd  = cmd;
            e.len  = len;
            e.data = data;
            e.last = last;
            expected_events.push_back(e);
        endfunction

        // Advance the frame parser by one accepted transaction.
        function void parse_rx_item(logic kind, logic [BYTE_W-1:0] c);
            int i;
            if (kind) begin
                if (elapsed != '1) elapsed = elapsed + TIME_W'(1);
                return;
            end
            if (elapsed >= timeout_ticks) phase = SEEK_HDR1;
            case (phase)
                SEEK_HDR1: begin
                    if (c == HDR_ONE) begin
                        elapsed = '0;
                        phase   = SEEK_HDR2;
                    end
                end
                SEEK_HDR2: phase = (c == HDR_TWO) ? GET_ADDR : SEEK_HDR1;
                GET_ADDR: begin
                    if (c != 0) begin
                        frm_addr = c;
                        run_sum  = c;
                        phase    = GET_CMD;
                    end else begin
                        phase = SEEK_HDR1;
                    end
                end
                GET_CMD: begin
                    frm_cmd = c;
                    run_sum = run_sum + c;
                    phase   = GET_LEN;
                end
                GET_LEN: begin
                    run_sum  = run_sum + c;
                    data_cnt = '0;
                    if (c == 0) begin
                        frm_len = '0;
                        phase   = GET_SUM;
                    end else if (c <= MAX_DATA) begin
                        frm_len = c[LEN_W-1:0];
                        phase   = GET_DATA;
                    end else begin
                        phase = SEEK_HDR1;
                    end
                end
                GET_DATA: begin
                    payload[data_cnt[3:0]] = c;
                    data_cnt = data_cnt + LEN_W'(1);
                    run_sum  = run_sum + c;
                    if (data_cnt >= frm_len) phase = GET_SUM;
                end
                GET_SUM: begin
                    if (c == run_sum) begin
                        if (frm_addr == own_addr) begin
                            push_event(EV_CMD, frm_cmd, frm_len, '0, frm_len == 0);
                            for (i = 0; i < frm_len; i++)
                                push_event(EV_DATA, frm_cmd, frm_len, payload[i],
                                           i + 1 == frm_len);
                        end
                    end else begin
                        push_event(EV_RESEND, '0, '0, '0, 1'b1);
                    end
                    phase = SEEK_HDR1;
                end
                default: phase = SEEK_HDR1;
            endcase
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            if (errors < 40)
                $display("mismatch at %0t: %s got 0x%0h expected 0x%0h",
                         $realtime, what, got, want);
            errors++;
        endtask

        task check_event(event_t ev, logic [23:0] td, logic tl);
            rx_event_t e;
            if (expected_events.size() == 0) begin
                report("unexpected result", td, 0);
                return;
            end
            e = expected_events.pop_front();
            if (ev !== e.ev) report("event", ev, e.ev);
            if (td[7:0] !== e.cmd) report("command", td[7:0], e.cmd);
            if (td[12:8] !== e.len) report("length", td[12:8], e.len);
            if (td[20:13] !== e.data) report("data byte", td[20:13], e.data);
            if (td[23:21] !== 3'b000) report("pad bits", td[23:21], 0);
            if (tl !== e.last) report("last", tl, e.last);
        endtask

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0]   cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    frame_scoreboard sb = new();
    rx_item_t        stim_q [$];
    int              idle_pct      = 0;
    int              stall_pct     = 0;
    int              tick_pct      = 0;
    bit              pressure_go   = 1'b0;
    bit              pressure_done = 1'b0;
    int              hold_count    = 0;
    int              quiet_cycles  = 0;

    framed_command_packet_receiver #(.MAX_DATA(MAX_DATA)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result side: check every accepted transaction, then pick the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_event(m_tuser, m_tdata, m_tlast);
        if (pressure_go && !pressure_done) begin
            m_tready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) pressure_done = 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function void push_item(logic kind, logic [7:0] b);
        rx_item_t it;
        it.kind = kind;
        it.rx   = b;
        stim_q.push_back(it);
    endfunction

    // Queue a byte, sometimes preceded by a tick with a random ignored byte.
    function void push_byte(logic [7:0] b);
        if ($urandom_range(99) < tick_pct) push_item(1'b1, 8'($urandom_range(255)));
        push_item(1'b0, b);
    endfunction

    function void push_frame(logic [7:0] addr, logic [7:0] cmd, logic [7:0] len, bit bad_sum);
        logic [7:0] sum;
        logic [7:0] d;
        int         i;
        push_byte(HDR_ONE);
        push_byte(HDR_TWO);
        push_byte(addr);
        push_byte(cmd);
        push_byte(len);
        sum = addr + cmd + len;
        for (i = 0; i < len; i++) begin
            d   = 8'($urandom_range(255));
            sum = sum + d;
            push_byte(d);
        end
        if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
        push_byte(sum);
    endfunction

    function void push_random_frame(logic [7:0] own);
        int         pick;
        int         i;
        logic [7:0] len;
        logic [7:0] b;
        pick = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? 8'($urandom_range(5, MAX_DATA))
                                        : 8'($urandom_range(0, 4));
        if (pick < 60) begin
            push_frame(own, 8'($urandom_range(255)), len, 1'b0);
        end else if (pick < 70) begin
            push_frame(8'($urandom_range(1, 255)), 8'($urandom_range(255)), len, 1'b0);
        end else if (pick < 80) begin
            push_frame($urandom_range(1) ? own : 8'($urandom_range(1, 255)),
                       8'($urandom_range(255)), len, 1'b1);
        end else if (pick < 86) begin
            push_byte(HDR_ONE);
            push_byte(HDR_TWO);
            push_byte(own);
            push_byte(8'($urandom_range(255)));
            push_byte(8'($urandom_range(MAX_DATA + 1, 255)));
        end else if (pick < 90) begin
            push_byte(HDR_ONE);
            push_byte(HDR_TWO);
            push_byte(8'h00);
        end else if (pick < 95) begin
            b = 8'($urandom_range(255));
            if (b == HDR_TWO) b = b ^ 8'h01;
            push_byte(HDR_ONE);
            push_byte(b);
        end else begin
            for (i = 0; i < $urandom_range(1, 3); i++) push_byte(8'($urandom_range(255)));
        end
    endfunction

    task send_item(logic kind, logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.parse_rx_item(kind, b);
    endtask

    task send_queued();
        rx_item_t it;
        while (stim_q.size() != 0) begin
            it = stim_q.pop_front();
            send_item(it.kind, it.rx);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold until every expected result is out, then let the pipeline settle.
    task wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task write_config(logic [7:0] own, logic [15:0] tmo);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_OWN_ADDR;
        cfg_wdata <= CFG_W'(own);
        @(posedge aclk);
        sb.set_reg(REG_OWN_ADDR, CFG_W'(own));
        cfg_addr  <= REG_TIMEOUT;
        cfg_wdata <= tmo;
        @(posedge aclk);
        sb.set_reg(REG_TIMEOUT, tmo);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    int         idle_tab  [4] = '{0, 67, 0, 37};
    int         stall_tab [4] = '{0, 0, 67, 37};
    logic [7:0] own_sel;
    int         ph;
    int         k;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: empty frame, zero address, bad second header,
        // oversized length, bad checksum on an empty frame.
        push_frame(OWN_ADDR_RST, 8'hFF, 8'd0, 1'b0);
        push_byte(HDR_ONE); push_byte(HDR_TWO); push_byte(8'h00);
        push_byte(HDR_ONE); push_byte(8'h00);
        push_byte(HDR_ONE); push_byte(HDR_TWO); push_byte(8'h01);
        push_byte(8'h00); push_byte(8'(MAX_DATA + 1));
        push_frame(8'h02, 8'h05, 8'd0, 1'b1);
        send_queued();
        wait_drained();

        // Timeout of one tick: a tick after the first header byte abandons the frame.
        write_config(8'd1, 16'd1);
        push_byte(HDR_ONE); push_item(1'b1, 8'h00); push_byte(HDR_TWO);
        push_frame(8'd1, 8'h00, 8'd0, 1'b0);
        send_queued();
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            tick_pct  = 15;
            case (ph)
                0: begin own_sel = 8'd255; write_config(own_sel, 16'hFFFF); end
                1: begin
                    own_sel = 8'($urandom_range(2, 254));
                    write_config(own_sel, 16'd100);
                end
                2: begin
                    own_sel = 8'd1;
                    write_config(own_sel, 16'($urandom_range(3, 12)));
                end
                default: begin
                    own_sel = 8'($urandom_range(1, 255));
                    write_config(own_sel, 16'($urandom_range(2, 8)));
                end
            endcase
            if (ph == 0) push_frame(own_sel, 8'($urandom_range(255)), 8'(MAX_DATA), 1'b0);
            while (stim_q.size() < 16) push_random_frame(own_sel);
            send_queued();
            wait_drained();
        end

        // Back-pressure: receiver holds off while full frames keep arriving.
        idle_pct  = 0;
        stall_pct = 0;
        tick_pct  = 0;
        own_sel   = 8'h5A;
        write_config(own_sel, 16'd1000);
        for (k = 0; k < 2; k++)
            push_frame(own_sel, 8'($urandom_range(255)), 8'(MAX_DATA), 1'b0);
        pressure_go = 1'b1;
        send_queued();
        wait_drained();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
